[rtl/laplace_edge_stencil_3x3_defines.svh]
// Assertion helpers used by the stencil RTL.
// Each use expects i_clk and i_rst_n in the enclosing module.
`ifndef LAPLACE_EDGE_STENCIL_3X3_DEFINES_SVH
`define LAPLACE_EDGE_STENCIL_3X3_DEFINES_SVH

// same-cycle implication
`define LES_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LES_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/les_pkg.sv]
package les_pkg;

    localparam int MAX_WIDTH     = 2048;
    localparam int PIXEL_BITS    = 8;
    localparam int COL_BITS      = $clog2(MAX_WIDTH);
    localparam int WEFF_BITS     = COL_BITS + 1;
    localparam int CFG_W_BITS    = 12;
    localparam int ROW_BITS      = 16;
    localparam int SUM_BITS      = PIXEL_BITS + 5;
    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_ADDR_BITS-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_KMODE  = 2'd2;

    localparam logic KMODE_FOUR  = 1'b0;
    localparam logic KMODE_EIGHT = 1'b1;

    localparam logic [CFG_W_BITS-1:0] RST_WIDTH  = 12'd512;
    localparam logic [ROW_BITS-1:0]   RST_HEIGHT = 16'd512;

    typedef logic [PIXEL_BITS-1:0] t_pix;

    // per-item position info, decided when the item is taken in
    typedef struct packed {
        logic primed;  // item produces a result
        logic last;    // that result closes the frame
        logic top;     // result pixel is on the first row
        logic bot;     // result pixel is on the last row
        logic left;    // first column
        logic right;   // last column
    } t_pos;

endpackage

[rtl/les_line_store.sv]
module les_line_store (
    input  logic                                i_clk,
    input  logic                                i_rd_en,
    input  logic [les_pkg::COL_BITS-1:0]        i_rd_addr,
    output logic [2*les_pkg::PIXEL_BITS-1:0]    o_rd_data,
    input  logic                                i_wr_en,
    input  logic [les_pkg::COL_BITS-1:0]        i_wr_addr,
    input  logic [2*les_pkg::PIXEL_BITS-1:0]    i_wr_data
);
    import les_pkg::*;

    // each entry: {two rows up, one row up}
    logic [2*PIXEL_BITS-1:0] mem [MAX_WIDTH];
    logic [2*PIXEL_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            // one-pixel rows hit the same entry back to back
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= i_wr_data;
            end else begin
                r_rd_data <= mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/les_frame_ctrl.sv]
`include "laplace_edge_stencil_3x3_defines.svh"

module les_frame_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  logic [les_pkg::CFG_W_BITS-1:0]   i_cfg_width,
    input  logic [les_pkg::ROW_BITS-1:0]     i_cfg_height,
    output logic [les_pkg::COL_BITS-1:0]     o_col,
    output les_pkg::t_pos                    o_pos
);
    import les_pkg::*;

    logic [COL_BITS-1:0]  r_in_col, n_in_col;
    logic [ROW_BITS-1:0]  r_in_row, n_in_row;
    logic [COL_BITS-1:0]  r_out_col, n_out_col;
    logic [ROW_BITS-1:0]  r_out_row, n_out_row;

    logic [WEFF_BITS-1:0] w_weff;
    logic [ROW_BITS-1:0]  w_heff;
    logic                 w_in_end;
    logic                 w_out_col_end;
    logic                 w_out_row_end;
    logic                 w_primed;
    logic                 w_last;

    always_comb begin
        if (i_cfg_width == '0) begin
            w_weff = WEFF_BITS'(1);
        end else if (32'(i_cfg_width) > 32'(MAX_WIDTH)) begin
            w_weff = WEFF_BITS'(MAX_WIDTH);
        end else begin
            w_weff = WEFF_BITS'(i_cfg_width);
        end
        w_heff = (i_cfg_height == '0) ? ROW_BITS'(1) : i_cfg_height;
    end

    assign w_in_end      = ({1'b0, r_in_col} + WEFF_BITS'(1)) >= w_weff;
    assign w_out_col_end = ({1'b0, r_out_col} + WEFF_BITS'(1)) >= w_weff;
    assign w_out_row_end = ({1'b0, r_out_row} + (ROW_BITS+1)'(1)) >= {1'b0, w_heff};
    assign w_primed      = (r_in_row >= ROW_BITS'(2))
                        || ((r_in_row == ROW_BITS'(1)) && (r_in_col != '0));
    assign w_last        = w_out_row_end && w_out_col_end;

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (i_accept) begin
            if (w_primed && w_last) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end else begin
                if (w_in_end) begin
                    n_in_col = '0;
                    if (r_in_row != '1) begin
                        n_in_row = r_in_row + ROW_BITS'(1);
                    end
                end else begin
                    n_in_col = r_in_col + COL_BITS'(1);
                end
                if (w_primed) begin
                    if (w_out_col_end) begin
                        n_out_col = '0;
                        n_out_row = r_out_row + ROW_BITS'(1);
                    end else begin
                        n_out_col = r_out_col + COL_BITS'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    assign o_col        = r_in_col;
    assign o_pos.primed = w_primed;
    assign o_pos.last   = w_last;
    assign o_pos.top    = (r_out_row == '0);
    assign o_pos.bot    = w_out_row_end;
    assign o_pos.left   = (r_out_col == '0);
    assign o_pos.right  = w_out_col_end;

    `LES_ASSERT_NXT(a_frame_wrap, i_accept && w_primed && w_last,
        (r_in_col == '0) && (r_in_row == '0) && (r_out_col == '0) && (r_out_row == '0),
        "counters not cleared after final result")
    `LES_ASSERT_IMP(a_out_idle_unprimed, !w_primed,
        (r_out_col == '0) && (r_out_row == '0),
        "output position moved before window filled")
    `LES_ASSERT_NXT(a_row_sat, (r_in_row == '1) && i_accept && !(w_primed && w_last),
        r_in_row == '1,
        "input row counter wrapped")

endmodule

[rtl/les_window.sv]
module les_window (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_shift,
    input  logic                      i_clear,
    input  les_pkg::t_pix             i_top,
    input  les_pkg::t_pix             i_mid,
    input  les_pkg::t_pix             i_px,
    input  les_pkg::t_pos             i_pos,
    input  logic                      i_kmode,
    output les_pkg::t_pix             o_edge
);
    import les_pkg::*;

    // entry col*3+row, col 0 oldest, row 0 top
    t_pix r_win [9];
    logic r_win_clr;
    t_pix w_base [9];

    t_pix v [3][3];
    t_pix c [3][3];
    logic signed [SUM_BITS-1:0] w_ring;
    logic signed [SUM_BITS-1:0] w_cross;
    logic signed [SUM_BITS-1:0] w_center;
    logic signed [SUM_BITS-1:0] w_sum;
    logic signed [SUM_BITS-1:0] w_mag;

    // the item after a frame end shifts into an empty window
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            w_base[k] = r_win_clr ? '0 : r_win[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
            r_win_clr <= 1'b0;
        end else if (i_shift) begin
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= w_base[k+3];
            end
            r_win[6]  <= i_top;
            r_win[7]  <= i_mid;
            r_win[8]  <= i_px;
            r_win_clr <= i_clear;
        end
    end

    // border replication: rows first, then columns
    always_comb begin
        for (int x = 0; x < 3; x++) begin
            v[x][0] = i_pos.top ? r_win[x*3+1] : r_win[x*3];
            v[x][1] = r_win[x*3+1];
            v[x][2] = i_pos.bot ? r_win[x*3+1] : r_win[x*3+2];
        end
        for (int y = 0; y < 3; y++) begin
            c[0][y] = i_pos.left  ? v[1][y] : v[0][y];
            c[1][y] = v[1][y];
            c[2][y] = i_pos.right ? v[1][y] : v[2][y];
        end
    end

    always_comb begin
        w_cross  = $signed(SUM_BITS'(c[1][0])) + $signed(SUM_BITS'(c[1][2]))
                 + $signed(SUM_BITS'(c[0][1])) + $signed(SUM_BITS'(c[2][1]));
        w_ring   = w_cross
                 + $signed(SUM_BITS'(c[0][0])) + $signed(SUM_BITS'(c[2][0]))
                 + $signed(SUM_BITS'(c[0][2])) + $signed(SUM_BITS'(c[2][2]));
        w_center = $signed(SUM_BITS'(c[1][1]));
        unique case (i_kmode)
            KMODE_EIGHT: w_sum = w_ring - (w_center <<< 3);
            default:     w_sum = w_cross - (w_center <<< 2);
        endcase
        w_mag = (w_sum < 0) ? -w_sum : w_sum;
        if (w_mag > $signed(SUM_BITS'(255))) begin
            o_edge = '1;
        end else begin
            o_edge = w_mag[PIXEL_BITS-1:0];
        end
    end

endmodule

[rtl/laplace_edge_stencil_3x3.sv]
// 3x3 Laplacian edge filter for 8-bit grey pixels in raster order.
// s_axis: tdata = pixel, tuser = flush (a flush item is taken as a zero
// pixel and pushes the pipeline). m_axis: tdata = |Laplacian| saturated at 255,
// tlast = final result of the frame. Config port: i_cfg_we writes
// i_cfg_data to register i_cfg_index (0 width, 1 height, 2 kernel mode).
// Throughput: one item per clock, back to back, while m_axis_tready does
// not hold the output; the line store does one read and one write per cycle.
// Alignment: the result for a pixel belongs to the item taken width+1 items
// later (source sends width+1 flush items after the frame); it reaches
// m_axis through the input stage, window stage and output register.
// Reset clears counters, window and config to 512x512, four-neighbour.
// Line store contents are not cleared; unwritten entries never reach a
// result in a well-formed frame.
// Stall: with m_axis_tready low the output register holds its result and
// any empty input or window stage still fills; s_axis_tready drops once
// both stages hold an item and the window stage's item has a result.
module laplace_edge_stencil_3x3 (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [7:0]                            s_axis_tdata,   // [7:0] pixel_in
    input  logic                                  s_axis_tuser,   // [0] flush
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [7:0]                            m_axis_tdata,   // [7:0] edge_value
    output logic                                  m_axis_tlast,
    input  logic                                  i_cfg_we,
    input  logic [les_pkg::CFG_ADDR_BITS-1:0]     i_cfg_index,
    input  logic [les_pkg::CFG_DATA_BITS-1:0]     i_cfg_data
);
    import les_pkg::*;

    logic [CFG_W_BITS-1:0] r_cfg_width;
    logic [ROW_BITS-1:0]   r_cfg_height;
    logic                  r_cfg_kmode;

    logic                  r_s1_v;
    t_pix                  r_s1_px;
    logic [COL_BITS-1:0]   r_s1_col;
    t_pos                  r_s1_pos;
    logic                  r_s2_v;
    t_pos                  r_s2_pos;
    logic                  r_o_v;
    t_pix                  r_o_edge;
    logic                  r_o_last;

    logic                  w_out_free;
    logic                  w_s2_go;
    logic                  w_s2_free;
    logic                  w_s1_go;
    logic                  w_s1_free;
    logic                  w_accept;
    logic [COL_BITS-1:0]   w_col;
    t_pos                  w_pos;
    logic [2*PIXEL_BITS-1:0] w_rd_data;
    t_pix                  w_edge;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= RST_WIDTH;
            r_cfg_height <= RST_HEIGHT;
            r_cfg_kmode  <= KMODE_FOUR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_WIDTH:  r_cfg_width  <= i_cfg_data[CFG_W_BITS-1:0];
                REG_HEIGHT: r_cfg_height <= i_cfg_data[ROW_BITS-1:0];
                REG_KMODE:  r_cfg_kmode  <= i_cfg_data[0];
                default:    ;
            endcase
        end
    end

    // stage handshake: items with no result leave the window stage freely
    assign w_out_free = !r_o_v || m_axis_tready;
    assign w_s2_go    = r_s2_v && (!r_s2_pos.primed || w_out_free);
    assign w_s2_free  = !r_s2_v || w_s2_go;
    assign w_s1_go    = r_s1_v && w_s2_free;
    assign w_s1_free  = !r_s1_v || w_s1_go;
    assign w_accept   = s_axis_tvalid && w_s1_free;

    les_frame_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_cfg_width  (r_cfg_width),
        .i_cfg_height (r_cfg_height),
        .o_col        (w_col),
        .o_pos        (w_pos)
    );

    les_line_store u_lines (
        .i_clk     (i_clk),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_col),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_s1_go),
        .i_wr_addr (r_s1_col),
        .i_wr_data ({w_rd_data[PIXEL_BITS-1:0], r_s1_px})
    );

    les_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (w_s1_go),
        .i_clear (r_s1_pos.primed && r_s1_pos.last),
        .i_top   (w_rd_data[2*PIXEL_BITS-1:PIXEL_BITS]),
        .i_mid   (w_rd_data[PIXEL_BITS-1:0]),
        .i_px    (r_s1_px),
        .i_pos   (r_s2_pos),
        .i_kmode (r_cfg_kmode),
        .o_edge  (w_edge)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_o_v  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_s1_v <= 1'b1;
            end else if (w_s1_go) begin
                r_s1_v <= 1'b0;
            end
            if (w_s1_go) begin
                r_s2_v <= 1'b1;
            end else if (w_s2_go) begin
                r_s2_v <= 1'b0;
            end
            if (w_s2_go && r_s2_pos.primed) begin
                r_o_v <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_px  <= s_axis_tuser ? '0 : s_axis_tdata;
            r_s1_col <= w_col;
            r_s1_pos <= w_pos;
        end
        if (w_s1_go) begin
            r_s2_pos <= r_s1_pos;
        end
        if (w_s2_go && r_s2_pos.primed) begin
            r_o_edge <= w_edge;
            r_o_last <= r_s2_pos.last;
        end
    end

    assign s_axis_tready = w_s1_free;
    assign m_axis_tvalid = r_o_v;
    assign m_axis_tdata  = r_o_edge;
    assign m_axis_tlast  = r_o_last;

endmodule

[tb/laplace_edge_stencil_3x3_test.sv]
`timescale 1ns / 100ps

module laplace_edge_stencil_3x3_test;
    import les_pkg::*;

    // index 3 is not mapped; a write there must change nothing
    localparam logic [CFG_ADDR_BITS-1:0] REG_UNMAPPED = 2'd3;
    localparam int unsigned ROW_CEIL = 16'hFFFF;
    localparam int          WIDE_COLS = 40;
    localparam int          RANDOM_ITEMS = 1200;

    typedef struct packed {
        t_pix magnitude;
        logic last;
    } t_lap_result;

    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [7:0]                s_axis_tdata  = '0;
    logic                      s_axis_tuser  = 1'b0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [7:0]                m_axis_tdata;
    logic                      m_axis_tlast;
    logic                      i_cfg_we      = 1'b0;
    logic [CFG_ADDR_BITS-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data    = '0;

    // predictor copy of registers and pipeline state
    logic [CFG_W_BITS-1:0] cur_width  = RST_WIDTH;
    logic [ROW_BITS-1:0]   cur_height = RST_HEIGHT;
    logic                  cur_kmode  = KMODE_FOUR;
    t_pix                  line_up1 [MAX_WIDTH];
    t_pix                  line_up2 [MAX_WIDTH];
    t_pix                  win [9];   // col*3+row, col 0 oldest
    int unsigned           in_col, in_row, out_col, out_row;

    t_lap_result pending_results [$];
    int          err_count   = 0;
    int          items_sent  = 0;
    int          src_gap_pct = 30;

    laplace_edge_stencil_3x3 u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial forever #4 i_clk = ~i_clk;

    initial begin
        #100_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int unsigned eff_width();
        if (cur_width == 0) return 1;
        if (cur_width > MAX_WIDTH) return MAX_WIDTH;
        return 32'(cur_width);
    endfunction

    function automatic int unsigned eff_height();
        return (cur_height == 0) ? 1 : 32'(cur_height);
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(99) < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    task automatic restart_frame();
        int k;
        for (k = 0; k < 9; k++) win[k] = '0;
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
    endtask

    // absolute 3x3 Laplacian with edge replication, one request at a time
    task automatic laplace_predict(input t_pix pix, input logic flush);
        int unsigned         w, h;
        logic [COL_BITS-1:0] col;
        t_pix                px, top, mid;
        bit                  primed, last;
        int                  nb [9];   // x*3+y
        int                  k, x, y, sum, mag;
        t_lap_result         res;
        w = eff_width();
        h = eff_height();
        px = flush ? t_pix'(0) : pix;
        col = (in_col < MAX_WIDTH) ? COL_BITS'(in_col) : COL_BITS'(MAX_WIDTH - 1);
        primed = (in_row >= 2) || (in_row == 1 && in_col >= 1);
        top = line_up2[col];
        mid = line_up1[col];
        line_up2[col] = mid;
        line_up1[col] = px;
        for (k = 0; k < 6; k++) win[k] = win[k + 3];
        win[6] = top;
        win[7] = mid;
        win[8] = px;
        if (in_col + 1 >= w) begin
            in_col = 0;
            if (in_row < ROW_CEIL) in_row++;
        end else begin
            in_col++;
        end
        if (primed) begin
            for (k = 0; k < 9; k++) nb[k] = int'(win[k]);
            for (x = 0; x < 3; x++) begin
                if (out_row == 0) nb[x*3] = nb[x*3+1];
                if (out_row + 1 >= h) nb[x*3+2] = nb[x*3+1];
            end
            for (y = 0; y < 3; y++) begin
                if (out_col == 0) nb[y] = nb[3+y];
                if (out_col + 1 >= w) nb[6+y] = nb[3+y];
            end
            if (cur_kmode == KMODE_EIGHT)
                sum = nb[0] + nb[3] + nb[6] + nb[1] + nb[7] + nb[2] + nb[5] + nb[8]
                    - 8 * nb[4];
            else
                sum = nb[3] + nb[5] + nb[1] + nb[7] - 4 * nb[4];
            mag = (sum < 0) ? -sum : sum;
            if (mag > 255) mag = 255;
            last = (out_row + 1 >= h) && (out_col + 1 >= w);
            res.magnitude = t_pix'(mag);
            res.last = last;
            pending_results.push_back(res);
            if (last) begin
                restart_frame();
            end else if (out_col + 1 >= w) begin
                out_col = 0;
                out_row++;
            end else begin
                out_col++;
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        unique case (idx)
            REG_WIDTH:  cur_width  = val[CFG_W_BITS-1:0];
            REG_HEIGHT: cur_height = val[ROW_BITS-1:0];
            REG_KMODE:  cur_kmode  = val[0];
            default: ;
        endcase
    endtask

    task automatic send_item(input t_pix pix, input logic flush);
        int gap;
        gap = ($urandom_range(99) < src_gap_pct) ? pick_gap() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tuser  <= flush;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
        laplace_predict(pix, flush);
    endtask

    // block is idle once every result is out and the last requests have left
    // the input and window stages
    task automatic wait_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // one frame of random pixels, then width+1 drain requests
    task automatic send_frame(input int flush_pct);
        int n, k;
        n = eff_width() * eff_height();
        for (k = 0; k < n; k++)
            send_item(t_pix'($urandom), $urandom_range(99) < flush_pct);
        for (k = 0; k <= eff_width(); k++)
            send_item(t_pix'($urandom), $urandom_range(99) >= 10);
    endtask

    task automatic test_directed();
        int k;
        // 3x2 frame, kernel mode left at its reset value
        write_reg(REG_WIDTH, 16'hF003);
        write_reg(REG_HEIGHT, 16'd2);
        write_reg(REG_UNMAPPED, 16'hFFFF);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        for (k = 0; k < 4; k++) send_item(8'hFF, 1'b1);
        wait_results();

        // zero height acts as one row; flush inside the frame counts as black
        write_reg(REG_WIDTH, 16'd2);
        write_reg(REG_HEIGHT, 16'd0);
        write_reg(REG_KMODE, CFG_DATA_BITS'(KMODE_EIGHT));
        send_item(8'hFF, 1'b0);
        send_item(8'hAA, 1'b1);
        for (k = 0; k < 3; k++) send_item(8'h00, 1'b1);
        wait_results();

        // 2x2 with a hold-off mid-frame until all results are out
        write_reg(REG_HEIGHT, 16'd2);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        wait_results();
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h7F, 1'b0);
        send_item(8'h00, 1'b1);
        send_item(8'h00, 1'b1);
        wait_results();
    endtask

    // widest rows of the random frames; fills every line store column they use
    task automatic test_wide_rows();
        write_reg(REG_WIDTH, CFG_DATA_BITS'(WIDE_COLS));
        write_reg(REG_HEIGHT, 16'd1);
        write_reg(REG_KMODE, 16'hFFFF);
        send_frame(3);
        wait_results();
        write_reg(REG_HEIGHT, 16'd2);
        write_reg(REG_KMODE, 16'hFFFE);
        send_frame(3);
        wait_results();
    endtask

    task automatic test_random_frames();
        int start, w, h, n, k, pick;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            wait_results();
            pick = $urandom_range(99);
            w = (pick < 80) ? $urandom_range(12, 1) :
                (pick < 96) ? $urandom_range(WIDE_COLS, 13) : 0;
            h = ($urandom_range(99) < 5) ? 0 : $urandom_range(6, 1);
            write_reg(REG_WIDTH, CFG_DATA_BITS'(w));
            write_reg(REG_HEIGHT, CFG_DATA_BITS'(h));
            write_reg(REG_KMODE, CFG_DATA_BITS'($urandom_range(1)));
            src_gap_pct = ($urandom_range(99) < 25) ? 0 : 30;
            pick = $urandom_range(99);
            if (pick < 80) begin
                send_frame(5);
            end else if (pick < 92) begin
                // cut short or overrun: leaves counters mid-frame for the next setting
                n = eff_width() * eff_height() + eff_width() + 1 + $urandom_range(6) - 3;
                for (k = 0; k < n; k++)
                    send_item(t_pix'($urandom), $urandom_range(99) < 20);
            end else begin
                n = $urandom_range(20, 1);
                for (k = 0; k < n; k++)
                    send_item(t_pix'($urandom), 1'($urandom_range(1)));
            end
        end
        src_gap_pct = 30;
    endtask

    initial begin : result_sink
        int stall, free_run;
        stall = 0;
        free_run = 0;
        forever begin
            @(posedge i_clk);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                stall--;
            end else begin
                m_axis_tready <= 1'b1;
                if (free_run > 0)
                    free_run--;
                else if ($urandom_range(99) < 3)
                    free_run = $urandom_range(200, 50);
                else if ($urandom_range(99) < 30)
                    stall = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_lap_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, got value %0d last %0b",
                         $time, m_axis_tdata, m_axis_tlast);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata !== want.magnitude) begin
                    $display("%0t: edge value mismatch: expected %0d, got %0d",
                             $time, want.magnitude, m_axis_tdata);
                    err_count++;
                end
                if (m_axis_tlast !== want.last) begin
                    $display("%0t: frame last mismatch: expected %0b, got %0b",
                             $time, want.last, m_axis_tlast);
                    err_count++;
                end
            end
        end
    end

    initial begin : run_tests
        int i;
        for (i = 0; i < MAX_WIDTH; i++) begin
            line_up1[i] = '0;
            line_up2[i] = '0;
        end
        restart_frame();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_wide_rows();
        test_random_frames();

        s_axis_tvalid <= 1'b0;
        for (i = 0; i < 20000 && pending_results.size() != 0; i++) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived",
                     $time, pending_results.size());
            err_count++;
        end
        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/les_pkg.sv
rtl/les_line_store.sv
rtl/les_frame_ctrl.sv
rtl/les_window.sv
rtl/laplace_edge_stencil_3x3.sv
tb/laplace_edge_stencil_3x3_test.sv
